// ----- src/lmeb_pkg.sv -----
// Shared types and constants for the list-mode event builder.
// Used by every module of the block; depends on nothing else.
package lmeb_pkg;

    localparam int WordWidth     = 32;
    localparam int StampWidth    = 48;
    localparam int RegWidth      = 28;
    localparam int HighWidth     = StampWidth - RegWidth;
    localparam int AdcWidth      = 16;
    localparam int FineWidth     = 13;
    localparam int CoarseWidth   = AdcWidth - FineWidth;
    localparam int TimeWidth     = 64;
    localparam int IdentWidth    = 12;
    localparam int SlotIdxWidth  = 2;
    localparam int NumSlots      = 4;
    localparam int FilledWidth   = 2 * NumSlots;
    localparam int CfgIndexWidth = 1;

    localparam int DefaultQueueDepth = 4;

    localparam logic [CfgIndexWidth-1:0] CfgEventWindow   = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgRolloverLimit = 1'b1;

    localparam logic [RegWidth-1:0] EventWindowReset   = 28'd10;
    localparam logic [RegWidth-1:0] RolloverLimitReset = 28'd26;

    localparam logic [WordWidth-1:0] FillZero    = 32'h0000_0000;
    localparam logic [WordWidth-1:0] FillPattern = 32'h5e5e_5e5e;
    localparam logic [WordWidth-1:0] FillOnes    = 32'hffff_ffff;

    localparam logic [1:0] DataTag = 2'b11;
    localparam logic [1:0] SyncTag = 2'b10;
    localparam logic [3:0] SyncCode = 4'h4;
    localparam logic [6:0] IgnoredCard = 7'd99;
    localparam logic [CoarseWidth-1:0] CoarseDrop = 3'd7;

    localparam logic [IdentWidth-1:0] IdSlowEnergyA = 12'd64;
    localparam logic [IdentWidth-1:0] IdSlowEnergyB = 12'd65;
    localparam logic [IdentWidth-1:0] IdFastEnergyA = 12'd72;
    localparam logic [IdentWidth-1:0] IdFastEnergyB = 12'd73;
    localparam logic [IdentWidth-1:0] IdSlowTimeA   = 12'd80;
    localparam logic [IdentWidth-1:0] IdSlowTimeB   = 12'd81;
    localparam logic [IdentWidth-1:0] IdFastTimeA   = 12'd88;
    localparam logic [IdentWidth-1:0] IdFastTimeB   = 12'd89;

    localparam logic [SlotIdxWidth-1:0] SlotSlowEnergyA = 2'd0;
    localparam logic [SlotIdxWidth-1:0] SlotSlowEnergyB = 2'd1;
    localparam logic [SlotIdxWidth-1:0] SlotFastEnergyA = 2'd2;
    localparam logic [SlotIdxWidth-1:0] SlotFastEnergyB = 2'd3;
    localparam logic [SlotIdxWidth-1:0] SlotFastTimeA   = 2'd0;
    localparam logic [SlotIdxWidth-1:0] SlotFastTimeB   = 2'd1;
    localparam logic [SlotIdxWidth-1:0] SlotSlowTimeA   = 2'd2;
    localparam logic [SlotIdxWidth-1:0] SlotSlowTimeB   = 2'd3;

    typedef struct packed {
        logic [StampWidth-1:0]   stamp;
        logic [AdcWidth-1:0]     adc;
        logic                    store_en;
        logic                    is_time;
        logic [SlotIdxWidth-1:0] slot;
    } lmeb_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lmeb_qstat_t;

endpackage

// ----- src/lmeb_front.sv -----
// Front end: takes list-mode words, drops fill and ignored words, tracks the
// timestamp state and queues classified data words. Depends on lmeb_pkg.
module lmeb_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lmeb_pkg::WordWidth-1:0]       s_ts_low_word,
    input  logic [lmeb_pkg::WordWidth-1:0]       s_payload_word,
    input  logic [lmeb_pkg::RegWidth-1:0]        rollover_limit,
    input  lmeb_pkg::lmeb_qstat_t                q_stat,
    output logic                                 push,
    output lmeb_pkg::lmeb_entry_t                push_entry
);
    import lmeb_pkg::*;

    logic [StampWidth-1:0] stamp_reg, stamp_next;
    logic                  rolled_reg, rolled_next;

    logic                  accept;
    logic                  is_fill;
    logic                  is_data;
    logic                  is_sync;
    logic                  is_card99;
    logic [IdentWidth-1:0] ident;
    logic [AdcWidth-1:0]   adc;
    logic [StampWidth-1:0] stamp_merged;
    logic [StampWidth-1:0] stamp_data;
    logic [StampWidth-1:0] stamp_sync;
    logic                  do_roll;

    always_comb begin
        s_ready = !q_stat.full;
        accept  = s_valid && !q_stat.full;

        is_fill = (s_ts_low_word == FillZero && s_payload_word == FillZero) ||
                  (s_ts_low_word == FillPattern && s_payload_word == FillPattern) ||
                  (s_ts_low_word == FillPattern && s_payload_word == FillOnes);
        is_data = s_payload_word[31:30] == DataTag;
        is_sync = s_payload_word[31:30] == SyncTag && s_payload_word[23:20] == SyncCode;
        ident     = s_payload_word[27:16];
        adc       = s_payload_word[AdcWidth-1:0];
        is_card99 = ident[IdentWidth-1:5] == IgnoredCard;

        stamp_merged = {stamp_reg[StampWidth-1:WordWidth],
                        stamp_reg[WordWidth-1:RegWidth] | s_ts_low_word[WordWidth-1:RegWidth],
                        s_ts_low_word[RegWidth-1:0]};
        do_roll = (s_ts_low_word <= {{(WordWidth-RegWidth){1'b0}}, rollover_limit}) &&
                  !rolled_reg;
        stamp_data = do_roll ?
            {stamp_merged[StampWidth-1:RegWidth] + HighWidth'(1), stamp_merged[RegWidth-1:0]} :
            stamp_merged;
        stamp_sync = {s_payload_word[HighWidth-1:WordWidth-RegWidth],
                      s_payload_word[WordWidth-RegWidth-1:0] |
                          s_ts_low_word[WordWidth-1:RegWidth],
                      s_ts_low_word[RegWidth-1:0]};

        push        = accept && !is_fill && is_data && !is_card99;
        stamp_next  = stamp_reg;
        rolled_next = rolled_reg;
        if (push) begin
            stamp_next  = stamp_data;
            rolled_next = rolled_reg || do_roll;
        end else if (accept && !is_fill && is_sync) begin
            stamp_next  = stamp_sync;
            rolled_next = 1'b0;
        end

        push_entry.stamp    = stamp_data;
        push_entry.adc      = adc;
        push_entry.store_en = 1'b0;
        push_entry.is_time  = 1'b0;
        push_entry.slot     = SlotSlowEnergyA;
        case (ident)
            IdSlowEnergyA: begin
                push_entry.store_en = 1'b1;
                push_entry.slot     = SlotSlowEnergyA;
            end
            IdSlowEnergyB: begin
                push_entry.store_en = 1'b1;
                push_entry.slot     = SlotSlowEnergyB;
            end
            IdFastEnergyA: begin
                push_entry.store_en = 1'b1;
                push_entry.slot     = SlotFastEnergyA;
            end
            IdFastEnergyB: begin
                push_entry.store_en = 1'b1;
                push_entry.slot     = SlotFastEnergyB;
            end
            IdSlowTimeA: begin
                push_entry.store_en = 1'b1;
                push_entry.is_time  = 1'b1;
                push_entry.slot     = SlotSlowTimeA;
            end
            IdSlowTimeB: begin
                push_entry.store_en = 1'b1;
                push_entry.is_time  = 1'b1;
                push_entry.slot     = SlotSlowTimeB;
            end
            IdFastTimeA: begin
                push_entry.store_en = adc[AdcWidth-1:FineWidth] != CoarseDrop;
                push_entry.is_time  = 1'b1;
                push_entry.slot     = SlotFastTimeA;
            end
            IdFastTimeB: begin
                push_entry.store_en = adc[AdcWidth-1:FineWidth] != CoarseDrop;
                push_entry.is_time  = 1'b1;
                push_entry.slot     = SlotFastTimeB;
            end
            default: begin
                push_entry.store_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg  <= '0;
            rolled_reg <= 1'b0;
        end else begin
            stamp_reg  <= stamp_next;
            rolled_reg <= rolled_next;
        end
    end

endmodule

// ----- src/lmeb_queue.sv -----
// Short queue of classified data words between the front and back ends.
// Depends on lmeb_pkg for the entry and status types.
module lmeb_queue #(
    parameter int DEPTH = lmeb_pkg::DefaultQueueDepth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lmeb_pkg::lmeb_entry_t push_entry,
    input  logic                  pop,
    output lmeb_pkg::lmeb_entry_t head_entry,
    output lmeb_pkg::lmeb_qstat_t q_stat
);
    import lmeb_pkg::*;

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);

    lmeb_entry_t           entries [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;

    always_comb begin
        q_stat.full  = count_reg == CountWidth'(DEPTH);
        q_stat.empty = count_reg == '0;
        head_entry   = entries[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("Queue written while full.");

    a_no_pop_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("Queue read while empty.");

    a_count_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue fill count lost a transaction.");

endmodule

// ----- src/lmeb_back.sv -----
// Back end: closes events on the timestamp gap, fills the detector slots and
// holds the finished event in the result register. Depends on lmeb_pkg.
module lmeb_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [lmeb_pkg::RegWidth-1:0]        event_window,
    input  lmeb_pkg::lmeb_qstat_t                q_stat,
    input  lmeb_pkg::lmeb_entry_t                head_entry,
    output logic                                 pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_slow_energy_a,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_slow_energy_b,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_fast_energy_a,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_fast_energy_b,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_fast_time_a,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_fast_time_b,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_slow_time_a,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_slow_time_b
);
    import lmeb_pkg::*;

    localparam int TickWidth = TimeWidth - FineWidth;

    logic [StampWidth-1:0]  prev_reg, prev_next;
    logic [StampWidth:0]    limit_reg, limit_next;
    logic [FilledWidth-1:0] filled_reg, filled_next;
    logic [AdcWidth-1:0]    energy_reg [NumSlots];
    logic [TimeWidth-1:0]   time_reg [NumSlots];
    logic                   m_valid_reg, m_valid_next;
    logic [AdcWidth-1:0]    out_energy_reg [NumSlots];
    logic [TimeWidth-1:0]   out_time_reg [NumSlots];

    logic                   head_valid;
    logic                   close;
    logic                   out_free;
    logic                   closing;
    logic [FilledWidth-1:0] filled_base;
    logic [TickWidth-1:0]   ticks_scaled;
    logic [TimeWidth-1:0]   time_value;
    logic                   write_energy;
    logic                   write_time;

    always_comb begin
        head_valid = !q_stat.empty;
        close      = {1'b0, head_entry.stamp} >= limit_reg;
        out_free   = !m_valid_reg || m_ready;
        pop        = head_valid && (!close || out_free);
        closing    = pop && close;

        // The stamp times 40960 is the stamp times five, shifted up by the fine bits.
        ticks_scaled = TickWidth'(head_entry.stamp) +
                       TickWidth'({head_entry.stamp, 2'b00}) +
                       TickWidth'(head_entry.adc[AdcWidth-1:FineWidth]);
        time_value   = {ticks_scaled, head_entry.adc[FineWidth-1:0]};

        prev_next  = pop ? head_entry.stamp : prev_reg;
        limit_next = {1'b0, prev_next} + (StampWidth + 1)'(event_window);

        filled_base  = closing ? '0 : filled_reg;
        write_energy = pop && head_entry.store_en && !head_entry.is_time &&
                       !filled_base[head_entry.slot];
        write_time   = pop && head_entry.store_en && head_entry.is_time &&
                       !filled_base[NumSlots + int'(head_entry.slot)];
        filled_next  = filled_base;
        if (write_energy) begin
            filled_next[head_entry.slot] = 1'b1;
        end
        if (write_time) begin
            filled_next[NumSlots + int'(head_entry.slot)] = 1'b1;
        end

        m_valid_next = closing ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            limit_reg   <= (StampWidth + 1)'(EventWindowReset);
            filled_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            prev_reg    <= prev_next;
            limit_reg   <= limit_next;
            filled_reg  <= filled_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_energy) begin
            energy_reg[head_entry.slot] <= head_entry.adc;
        end
        if (write_time) begin
            time_reg[head_entry.slot] <= time_value;
        end
        if (closing) begin
            for (int k = 0; k < NumSlots; k++) begin
                out_energy_reg[k] <= filled_reg[k] ? energy_reg[k] : '0;
                out_time_reg[k]   <= filled_reg[NumSlots + k] ? time_reg[k] : '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slow_energy_a = out_energy_reg[SlotSlowEnergyA];
    assign m_slow_energy_b = out_energy_reg[SlotSlowEnergyB];
    assign m_fast_energy_a = out_energy_reg[SlotFastEnergyA];
    assign m_fast_energy_b = out_energy_reg[SlotFastEnergyB];
    assign m_fast_time_a   = out_time_reg[SlotFastTimeA];
    assign m_fast_time_b   = out_time_reg[SlotFastTimeB];
    assign m_slow_time_a   = out_time_reg[SlotSlowTimeA];
    assign m_slow_time_b   = out_time_reg[SlotSlowTimeB];

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> !$past(closing))
        else $error("A pending event was overwritten by a new one.");

    a_new_event_one_slot : assert property (@(posedge aclk) disable iff (!aresetn)
        closing |=> $countones(filled_reg) <= 1)
        else $error("Slots were not cleared when an event closed.");

endmodule

// ----- src/listmode_event_builder.sv -----
// Top level of the list-mode event builder: configuration registers and the
// front end, queue and back end. Depends on lmeb_pkg, lmeb_front, lmeb_queue, lmeb_back.
//
//   Channel   Direction  Handshake          Content
//   s_        in         s_valid/s_ready    one 64-bit list-mode word per transaction
//   m_        out        m_valid/m_ready    one closed event per transaction
//   cfg_      in         cfg_wr_en          event_window (0), rollover_limit (1)
//
// One word is accepted every cycle while s_ready is high; the back end pops registered
// queue words in order and loads each closed event into the result register on its pop.
// The gap compare and slot update run once per queued word in the back end.
// Reset is synchronous; the slot contents need no clearing pass.
// s_ready falls only when QUEUE_DEPTH data words wait behind a held result.
module listmode_event_builder #(
    parameter int QUEUE_DEPTH = lmeb_pkg::DefaultQueueDepth
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lmeb_pkg::WordWidth-1:0]       s_ts_low_word,
    input  logic [lmeb_pkg::WordWidth-1:0]       s_payload_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_slow_energy_a,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_slow_energy_b,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_fast_energy_a,
    output logic [lmeb_pkg::AdcWidth-1:0]        m_fast_energy_b,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_fast_time_a,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_fast_time_b,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_slow_time_a,
    output logic [lmeb_pkg::TimeWidth-1:0]       m_slow_time_b,
    input  logic                                 cfg_wr_en,
    input  logic [lmeb_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [lmeb_pkg::RegWidth-1:0]        cfg_wr_data
);
    import lmeb_pkg::*;

    logic [RegWidth-1:0] event_window_reg, event_window_next;
    logic [RegWidth-1:0] rollover_limit_reg, rollover_limit_next;

    logic        push;
    logic        pop;
    lmeb_entry_t push_entry;
    lmeb_entry_t head_entry;
    lmeb_qstat_t q_stat;

    always_comb begin
        event_window_next   = event_window_reg;
        rollover_limit_next = rollover_limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CfgEventWindow:   event_window_next   = cfg_wr_data;
                CfgRolloverLimit: rollover_limit_next = cfg_wr_data;
                default: begin
                    event_window_next = event_window_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_window_reg   <= EventWindowReset;
            rollover_limit_reg <= RolloverLimitReset;
        end else begin
            event_window_reg   <= event_window_next;
            rollover_limit_reg <= rollover_limit_next;
        end
    end

    lmeb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ts_low_word  (s_ts_low_word),
        .s_payload_word (s_payload_word),
        .rollover_limit (rollover_limit_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_entry     (push_entry)
    );

    lmeb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    lmeb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .event_window    (event_window_reg),
        .q_stat          (q_stat),
        .head_entry      (head_entry),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slow_energy_a (m_slow_energy_a),
        .m_slow_energy_b (m_slow_energy_b),
        .m_fast_energy_a (m_fast_energy_a),
        .m_fast_energy_b (m_fast_energy_b),
        .m_fast_time_a   (m_fast_time_a),
        .m_fast_time_b   (m_fast_time_b),
        .m_slow_time_a   (m_slow_time_a),
        .m_slow_time_b   (m_slow_time_b)
    );

endmodule

// ----- bench/tb_listmode_event_builder.sv -----
`timescale 1ns / 1ps
// Self-checking bench for listmode_event_builder: directed and random list-mode words
// are checked against a scoreboard that predicts every closed event. Needs lmeb_pkg and the RTL.
module tb_listmode_event_builder;
    import lmeb_pkg::*;

    localparam int NumPhases     = 8;
    localparam int PhaseWords    = 164;
    localparam int SettleCycles  = DefaultQueueDepth + 12;
    localparam int HoldCycles    = 300;
    localparam int WatchdogLimit = 5000;
    localparam int MaxReports    = 10;
    localparam int PressurePhase = 4;
    localparam int PausePhase    = 5;

    localparam logic [StampWidth-1:0] HighMask = {{HighWidth{1'b1}}, {RegWidth{1'b0}}};
    localparam logic [StampWidth-1:0] RollStep =
        {{(HighWidth-1){1'b0}}, 1'b1, {RegWidth{1'b0}}};
    localparam logic [TimeWidth-1:0] TickUnits = 64'd40960;

    typedef struct {
        logic [AdcWidth-1:0]  energy [NumSlots];
        logic [TimeWidth-1:0] times [NumSlots];
    } event_rec_t;

    class event_scoreboard;
        logic [RegWidth-1:0]    window     = EventWindowReset;
        logic [RegWidth-1:0]    roll_limit = RolloverLimitReset;
        logic [StampWidth-1:0]  cur_stamp  = '0;
        logic [StampWidth-1:0]  prev_stamp = '0;
        logic                   roll_done  = 1'b0;
        logic [AdcWidth-1:0]    energy [NumSlots];
        logic [TimeWidth-1:0]   times [NumSlots];
        logic [FilledWidth-1:0] filled     = '0;
        event_rec_t             pending [$];
        int                     errors     = 0;

        function void set_register(logic [CfgIndexWidth-1:0] idx, logic [RegWidth-1:0] value);
            if (idx == CfgEventWindow)
                window = value;
            else if (idx == CfgRolloverLimit)
                roll_limit = value;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MaxReports)
                $display("Mismatch: %s", msg);
        endfunction

        function void put_energy(logic [SlotIdxWidth-1:0] s, logic [AdcWidth-1:0] adc);
            if (!filled[s]) begin
                energy[s] = adc;
                filled[s] = 1'b1;
            end
        endfunction

        function void put_time(logic [SlotIdxWidth-1:0] s, logic [TimeWidth-1:0] value);
            if (!filled[s + NumSlots]) begin
                times[s] = value;
                filled[s + NumSlots] = 1'b1;
            end
        endfunction

        function void note_word(logic [WordWidth-1:0] lo, logic [WordWidth-1:0] pay);
            logic [IdentWidth-1:0] ident;
            logic [AdcWidth-1:0]   adc;
            logic [StampWidth-1:0] ts;
            logic [TimeWidth-1:0]  t;
            longint                gap;
            event_rec_t            ev;
            int                    k;
            ident = pay[27:16];
            adc = pay[AdcWidth-1:0];
            if ((lo == FillZero && pay == FillZero) ||
                (lo == FillPattern && (pay == FillPattern || pay == FillOnes)))
                return;
            if (pay[31:30] == DataTag) begin
                if (ident[IdentWidth-1:5] == IgnoredCard)
                    return;
                ts = (cur_stamp & HighMask) | {{(StampWidth-WordWidth){1'b0}}, lo};
                if (lo <= {4'b0, roll_limit} && !roll_done) begin
                    ts = ts + RollStep;
                    roll_done = 1'b1;
                end
                cur_stamp = ts;
                gap = longint'({16'b0, ts}) - longint'({16'b0, prev_stamp});
                if (gap >= longint'({36'b0, window})) begin
                    for (k = 0; k < NumSlots; k++) begin
                        ev.energy[k] = filled[k] ? energy[k] : '0;
                        ev.times[k] = filled[k + NumSlots] ? times[k] : '0;
                    end
                    pending = {pending, ev};
                    filled = '0;
                end
                t = {{(TimeWidth-StampWidth){1'b0}}, ts} * TickUnits +
                    {{(TimeWidth-AdcWidth){1'b0}}, adc};
                case (ident)
                    IdSlowEnergyA: put_energy(SlotSlowEnergyA, adc);
                    IdSlowEnergyB: put_energy(SlotSlowEnergyB, adc);
                    IdFastEnergyA: put_energy(SlotFastEnergyA, adc);
                    IdFastEnergyB: put_energy(SlotFastEnergyB, adc);
                    IdSlowTimeA:   put_time(SlotSlowTimeA, t);
                    IdSlowTimeB:   put_time(SlotSlowTimeB, t);
                    IdFastTimeA, IdFastTimeB: begin
                        if (adc[AdcWidth-1:FineWidth] != CoarseDrop)
                            put_time((ident == IdFastTimeA) ? SlotFastTimeA : SlotFastTimeB, t);
                    end
                    default: ;
                endcase
                prev_stamp = ts;
            end else if (pay[31:30] == SyncTag && pay[23:20] == SyncCode) begin
                cur_stamp = {pay[HighWidth-1:0], {RegWidth{1'b0}}} |
                            {{(StampWidth-WordWidth){1'b0}}, lo};
                roll_done = 1'b0;
            end
        endfunction

        function void check_event(event_rec_t got);
            string energy_name [NumSlots] =
                '{"slow_energy_a", "slow_energy_b", "fast_energy_a", "fast_energy_b"};
            string time_name [NumSlots] =
                '{"fast_time_a", "fast_time_b", "slow_time_a", "slow_time_b"};
            event_rec_t want;
            int k;
            if (pending.size() == 0) begin
                note_error($sformatf("event with none expected: slow_energy_a %h, fast_time_a %h",
                                     got.energy[0], got.times[0]));
                return;
            end
            want = pending.pop_front();
            for (k = 0; k < NumSlots; k++) begin
                if (got.energy[k] !== want.energy[k])
                    note_error($sformatf("%s: expected %h, actual %h", energy_name[k],
                                         want.energy[k], got.energy[k]));
                if (got.times[k] !== want.times[k])
                    note_error($sformatf("%s: expected %h, actual %h", time_name[k],
                                         want.times[k], got.times[k]));
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic [WordWidth-1:0]     s_ts_low_word   = '0;
    logic [WordWidth-1:0]     s_payload_word  = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [AdcWidth-1:0]      m_slow_energy_a;
    logic [AdcWidth-1:0]      m_slow_energy_b;
    logic [AdcWidth-1:0]      m_fast_energy_a;
    logic [AdcWidth-1:0]      m_fast_energy_b;
    logic [TimeWidth-1:0]     m_fast_time_a;
    logic [TimeWidth-1:0]     m_fast_time_b;
    logic [TimeWidth-1:0]     m_slow_time_a;
    logic [TimeWidth-1:0]     m_slow_time_b;
    logic                     cfg_wr_en       = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index       = CfgEventWindow;
    logic [RegWidth-1:0]      cfg_wr_data     = '0;

    event_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_asked     = 0;
    int          hold_taken     = 0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;
    int unsigned step_span      = 32;
    int unsigned cur_limit      = 32'(RolloverLimitReset);
    logic [WordWidth-1:0] gen_lo = '0;
    logic [HighWidth-1:0] gen_hi = '0;

    logic [IdentWidth-1:0] known_ids [8] = '{IdSlowEnergyA, IdSlowEnergyB, IdFastEnergyA,
        IdFastEnergyB, IdSlowTimeA, IdSlowTimeB, IdFastTimeA, IdFastTimeB};
    logic [IdentWidth-1:0] odd_ids [8] =
        '{12'd0, 12'd63, 12'd66, 12'd71, 12'd74, 12'd82, 12'd3167, 12'd3200};

    int unsigned phase_window [NumPhases] = '{10, 0, 28'hfffffff, 1000, 1, 20, 5, 10};
    int unsigned phase_limit [NumPhases]  = '{26, 0, 28'hfffffff, 500, 100, 26, 28'hffffff, 26};
    int          phase_send [NumPhases]   = '{0, 64, 0, 9, 0, 64, 0, 9};
    int          phase_recv [NumPhases]   = '{0, 0, 64, 9, 0, 0, 64, 9};

    listmode_event_builder u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin : result_side
        event_rec_t got;
        if (aresetn && m_valid && m_ready) begin
            got.energy[0] = m_slow_energy_a;
            got.energy[1] = m_slow_energy_b;
            got.energy[2] = m_fast_energy_a;
            got.energy[3] = m_fast_energy_b;
            got.times[0] = m_fast_time_a;
            got.times[1] = m_fast_time_b;
            got.times[2] = m_slow_time_a;
            got.times[3] = m_slow_time_b;
            sb.check_event(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HoldCycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [WordWidth-1:0] data_word(logic [IdentWidth-1:0] ident,
                                                       logic [AdcWidth-1:0] adc);
        logic [1:0] spare;
        spare = 2'($urandom);
        return {DataTag, spare, ident, adc};
    endfunction

    function automatic logic [WordWidth-1:0] sync_word(logic [HighWidth-1:0] hi);
        logic [5:0] spare;
        spare = 6'($urandom);
        return {SyncTag, spare, SyncCode, hi};
    endfunction

    task automatic send_word(input logic [WordWidth-1:0] lo, input logic [WordWidth-1:0] pay);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ts_low_word <= lo;
        s_payload_word <= pay;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(lo, pay);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [RegWidth-1:0] window,
                                   input logic [RegWidth-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= CfgEventWindow;
        cfg_wr_data <= window;
        @(posedge aclk);
        sb.set_register(CfgEventWindow, window);
        cfg_index <= CfgRolloverLimit;
        cfg_wr_data <= limit;
        @(posedge aclk);
        sb.set_register(CfgRolloverLimit, limit);
        cfg_wr_en <= 1'b0;
        cur_limit = 32'(limit);
        if (window == 0)
            step_span = 4;
        else if (window > 1000)
            step_span = 3000;
        else
            step_span = 3 * window + 2;
    endtask

    // Mostly data words on a slowly advancing stamp so that events open and close,
    // mixed with syncs, rollover candidates, fills, ignored cards and noise.
    task automatic random_word(output logic [WordWidth-1:0] lo, output logic [WordWidth-1:0] pay,
                               output bit counted);
        int pick;
        int sel;
        logic [IdentWidth-1:0] ident;
        logic [AdcWidth-1:0]   adc;
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 78) begin
            if (sel < 60)
                gen_lo = gen_lo + $urandom_range(0, step_span);
            else if (sel < 70)
                gen_lo = gen_lo + $urandom_range(0, 15);
            else if (sel < 78)
                gen_lo = $urandom_range(0, cur_limit + 3);
            else if (sel < 86)
                gen_lo = gen_lo - $urandom_range(0, step_span);
            else if (sel < 94)
                gen_lo = $urandom;
            else
                gen_lo = gen_lo + $urandom_range(0, 32'h1fff_ffff);
            sel = $urandom_range(0, 99);
            if (sel < 80)
                ident = known_ids[$urandom_range(0, 7)];
            else if (sel < 90)
                ident = odd_ids[$urandom_range(0, 7)];
            else
                ident = IdentWidth'($urandom);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                adc = '0;
            else if (sel == 1)
                adc = '1;
            else
                adc = AdcWidth'($urandom);
            lo = gen_lo;
            pay = data_word(ident, adc);
        end else if (pick < 86) begin
            if (sel < 70)
                gen_hi = gen_hi + HighWidth'($urandom_range(0, 1));
            else
                gen_hi = HighWidth'($urandom);
            if ($urandom_range(0, 1) == 1)
                gen_lo = $urandom_range(0, 255);
            lo = gen_lo;
            pay = sync_word(gen_hi);
        end else begin
            counted = 1'b0;
            if (pick < 90) begin
                case (sel % 3)
                    0: begin
                        lo = FillZero;
                        pay = FillZero;
                    end
                    1: begin
                        lo = FillPattern;
                        pay = FillPattern;
                    end
                    default: begin
                        lo = FillPattern;
                        pay = FillOnes;
                    end
                endcase
            end else if (pick < 94) begin
                lo = $urandom;
                pay = data_word({IgnoredCard, 5'($urandom)}, AdcWidth'($urandom));
            end else begin
                lo = $urandom;
                pay = $urandom;
            end
        end
    endtask

    initial begin
        logic [WordWidth-1:0] lo;
        logic [WordWidth-1:0] pay;
        bit                   counted;
        int                   done;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first data word after reset closes an empty event.
        send_word(32'd100, data_word(IdSlowEnergyA, 16'hffff));
        send_word(FillZero, FillZero);
        send_word(FillPattern, FillPattern);
        send_word(FillPattern, FillOnes);
        send_word(32'd5000, data_word({IgnoredCard, 5'd0}, 16'h1234));
        send_word(32'd5000, data_word({IgnoredCard, 5'h1f}, 16'hffff));
        send_word(32'd102, data_word(IdSlowEnergyB, 16'h0000));
        send_word(32'd103, data_word(IdFastEnergyA, 16'h1234));
        send_word(32'd103, data_word(IdFastEnergyB, 16'hffff));
        send_word(32'd104, data_word(IdFastTimeA, 16'he000));
        send_word(32'd104, data_word(IdFastTimeA, 16'h1fff));
        send_word(32'd105, data_word(IdFastTimeB, 16'hdfff));
        send_word(32'd105, data_word(IdSlowTimeA, 16'hffff));
        send_word(32'd106, data_word(IdSlowTimeB, 16'h0000));
        send_word(32'd107, data_word(IdSlowEnergyA, 16'h5555));
        send_word(32'd108, data_word(12'd0, 16'h7777));
        send_word(32'h0000_5555, 32'h0000_1234);
        // Sync with overlapping halves, then a rollover that wraps the stamp backwards.
        send_word(32'hffff_ffff, sync_word(20'hfffff));
        send_word(32'd5, data_word(IdFastEnergyA, 16'h4321));
        send_word(32'd3, data_word(IdSlowTimeB, 16'h0001));
        send_word(32'hffff_ffff, data_word(IdSlowTimeA, 16'habcd));
        send_word(32'd0, sync_word(20'd0));
        send_word(32'd26, data_word(IdFastTimeB, 16'h2000));
        send_word(32'h1000_0024, data_word(IdFastTimeA, 16'h0000));
        send_word(32'h1000_002d, data_word(IdSlowEnergyB, 16'h0f0f));
        send_word(32'h1000_0037, FillOnes);

        for (int p = 0; p < NumPhases; p++) begin
            settle();
            write_registers(RegWidth'(phase_window[p]), RegWidth'(phase_limit[p]));
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            done = 0;
            while (done < PhaseWords) begin
                random_word(lo, pay, counted);
                if (counted) begin
                    done++;
                    if (p == PressurePhase && done == PhaseWords / 2)
                        hold_asked++;
                    if (p == PausePhase && done == PhaseWords / 2)
                        settle();
                end
                send_word(lo, pay);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
